@@ hdl/qltu_pkg.sv @@
package qltu_pkg;

	// Table geometry
	localparam int NUM_STATES  = 256;
	localparam int NUM_ACTIONS = 8;
	localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);

	// Field widths
	localparam int STATE_W  = 8;
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int COEF_W   = 17;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TRAINING_ENABLE      = 3'd0,
		REG_LEARNING_RATE        = 3'd1,
		REG_DISCOUNT             = 3'd2,
		REG_CLIP_ENABLE          = 3'd3,
		REG_CLIP_LOW             = 3'd4,
		REG_CLIP_HIGH            = 3'd5,
		REG_NORMALIZE_ENABLE     = 3'd6,
		REG_NORMALIZE_RECIPROCAL = 3'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic              RST_TRAINING_ENABLE      = 1'b1;
	localparam logic [COEF_W-1:0] RST_LEARNING_RATE        = 17'd6554;
	localparam logic [COEF_W-1:0] RST_DISCOUNT             = 17'd58982;
	localparam logic              RST_CLIP_ENABLE          = 1'b1;
	localparam logic [VALUE_W-1:0] RST_CLIP_LOW            = 32'hFC18_0000;
	localparam logic [VALUE_W-1:0] RST_CLIP_HIGH           = 32'h03E8_0000;
	localparam logic              RST_NORMALIZE_ENABLE     = 1'b0;
	localparam logic [VALUE_W-1:0] RST_NORMALIZE_RECIPROCAL = 32'h0001_0000;

	typedef struct packed {
		logic [STATE_W-1:0]         cur_state;
		logic [ACTION_W-1:0]        taken_action;
		logic signed [VALUE_W-1:0]  reward_value;
		logic [STATE_W-1:0]         following_state;
		logic                       episode_done;
	} transition_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] updated_q;
		logic signed [VALUE_W-1:0] best_next_q;
		logic                      was_updated;
	} result_t;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_READ  = 7'b0000100,
		S_CUR   = 7'b0001000,
		S_SUM   = 7'b0010000,
		S_ALPHA = 7'b0100000,
		S_WB    = 7'b1000000
	} state_t;

endpackage

@@ hdl/q_learning_table_update_unit.sv @@
// Q-learning table update: one transition request in, one result out.
// A new request is taken only in idle, after the previous one has retired; the next-state row
// is read by a serial scan of the table memory (one read a cycle), then the current entry.
// Reset: asynchronous, active low; configuration registers return to their defaults and a
// clearing pass writes zero to all 2048 table entries before the first request.
// Configuration writes are taken in every cycle.
module q_learning_table_update_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tr_valid,
	output logic                             tr_stall,
	input  qltu_pkg::transition_t            tr_data,
	output logic                             rs_valid,
	input  logic                             rs_stall,
	output qltu_pkg::result_t                rs_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qltu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [qltu_pkg::VALUE_W-1:0]     cfg_data
);

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [qltu_pkg::VALUE_W-1:0] sat32(
		input logic signed [64:0] x
	);
		logic hi_same;
		hi_same = (&x[64:31]) | ~(|x[64:31]);
		if (hi_same) begin
			sat32 = x[31:0];
		end else if (x[64]) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = 32'h7FFF_FFFF;
		end
	endfunction

	// Flat table address of (state, action)
	function automatic logic [qltu_pkg::ADDR_W-1:0] tbl_addr(
		input logic [qltu_pkg::STATE_W-1:0]  st,
		input logic [qltu_pkg::ADDR_W-1:0]   act
	);
		tbl_addr = qltu_pkg::ADDR_W'(st) * qltu_pkg::ADDR_W'(qltu_pkg::NUM_ACTIONS) + act;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                               train_en_q;
	logic [qltu_pkg::COEF_W-1:0]        alpha_q;
	logic [qltu_pkg::COEF_W-1:0]        gamma_q;
	logic                               clip_en_q;
	logic signed [qltu_pkg::VALUE_W-1:0] clip_lo_q;
	logic signed [qltu_pkg::VALUE_W-1:0] clip_hi_q;
	logic                               norm_en_q;
	logic [qltu_pkg::VALUE_W-1:0]       recip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_en_q <= qltu_pkg::RST_TRAINING_ENABLE;
			alpha_q    <= qltu_pkg::RST_LEARNING_RATE;
			gamma_q    <= qltu_pkg::RST_DISCOUNT;
			clip_en_q  <= qltu_pkg::RST_CLIP_ENABLE;
			clip_lo_q  <= qltu_pkg::RST_CLIP_LOW;
			clip_hi_q  <= qltu_pkg::RST_CLIP_HIGH;
			norm_en_q  <= qltu_pkg::RST_NORMALIZE_ENABLE;
			recip_q    <= qltu_pkg::RST_NORMALIZE_RECIPROCAL;
		end else if (cfg_valid && cfg_ready) begin
			case (qltu_pkg::cfg_reg_t'(cfg_index))
				qltu_pkg::REG_TRAINING_ENABLE:      train_en_q <= cfg_data[0];
				qltu_pkg::REG_LEARNING_RATE:        alpha_q    <= cfg_data[qltu_pkg::COEF_W-1:0];
				qltu_pkg::REG_DISCOUNT:             gamma_q    <= cfg_data[qltu_pkg::COEF_W-1:0];
				qltu_pkg::REG_CLIP_ENABLE:          clip_en_q  <= cfg_data[0];
				qltu_pkg::REG_CLIP_LOW:             clip_lo_q  <= cfg_data;
				qltu_pkg::REG_CLIP_HIGH:            clip_hi_q  <= cfg_data;
				qltu_pkg::REG_NORMALIZE_ENABLE:     norm_en_q  <= cfg_data[0];
				qltu_pkg::REG_NORMALIZE_RECIPROCAL: recip_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	qltu_pkg::state_t                  state_q;
	logic [qltu_pkg::ADDR_W-1:0]       clr_q;
	logic [qltu_pkg::CNT_W-1:0]        cnt_q;
	logic                              tr_acc;
	logic                              wb_go;
	logic                              rs_valid_q;
	qltu_pkg::result_t                 rs_q;

	// Accept only in idle; the result register parts the output side
	assign tr_stall = (state_q != qltu_pkg::S_IDLE);
	assign tr_acc   = tr_valid && !tr_stall;
	// Retire only when the result register is free or being drained
	assign wb_go    = (state_q == qltu_pkg::S_WB) && (!rs_valid_q || !rs_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qltu_pkg::S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				qltu_pkg::S_CLEAR: begin
					clr_q <= clr_q + qltu_pkg::ADDR_W'(1);
					if (clr_q == qltu_pkg::ADDR_W'(qltu_pkg::DEPTH - 1)) begin
						state_q <= qltu_pkg::S_IDLE;
					end
				end
				qltu_pkg::S_IDLE: begin
					// Row entry 0 is read in the accept cycle
					if (tr_acc) begin
						cnt_q   <= qltu_pkg::CNT_W'(1);
						state_q <= qltu_pkg::S_READ;
					end
				end
				qltu_pkg::S_READ: begin
					cnt_q <= cnt_q + qltu_pkg::CNT_W'(1);
					// Last read cycle fetches the current entry
					if (cnt_q == qltu_pkg::CNT_W'(qltu_pkg::NUM_ACTIONS)) begin
						state_q <= qltu_pkg::S_CUR;
					end
				end
				qltu_pkg::S_CUR:   state_q <= qltu_pkg::S_SUM;
				qltu_pkg::S_SUM:   state_q <= qltu_pkg::S_ALPHA;
				qltu_pkg::S_ALPHA: state_q <= qltu_pkg::S_WB;
				qltu_pkg::S_WB: begin
					if (wb_go) begin
						state_q <= qltu_pkg::S_IDLE;
					end
				end
				default: state_q <= qltu_pkg::S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Request capture
	// ------------------------------------------------------------------
	logic [qltu_pkg::STATE_W-1:0]        s_q;
	logic [qltu_pkg::ACTION_W-1:0]       a_q;
	logic [qltu_pkg::STATE_W-1:0]        ns_q;
	logic                                zero_best_q;
	logic                                in_range_q;
	logic signed [qltu_pkg::VALUE_W-1:0] r_lo;
	logic signed [qltu_pkg::VALUE_W-1:0] r_clip;
	logic signed [qltu_pkg::VALUE_W-1:0] r_clip_q;

	// Low clamp first, then high clamp: crossed bounds give the high bound
	always_comb begin
		r_lo   = (tr_data.reward_value < clip_lo_q) ? clip_lo_q : tr_data.reward_value;
		r_clip = (r_lo > clip_hi_q) ? clip_hi_q : r_lo;
		if (!clip_en_q) begin
			r_clip = tr_data.reward_value;
		end
	end

	always_ff @(posedge clk) begin
		if (tr_acc) begin
			s_q         <= tr_data.cur_state;
			a_q         <= tr_data.taken_action;
			ns_q        <= tr_data.following_state;
			zero_best_q <= tr_data.episode_done ||
				(32'(tr_data.following_state) >= 32'(qltu_pkg::NUM_STATES));
			in_range_q  <= (32'(tr_data.cur_state) < 32'(qltu_pkg::NUM_STATES)) &&
				(32'(tr_data.taken_action) < 32'(qltu_pkg::NUM_ACTIONS));
			r_clip_q    <= r_clip;
		end
	end

	// ------------------------------------------------------------------
	// Table memory: one read port, one write port, registered read data
	// ------------------------------------------------------------------
	logic [qltu_pkg::VALUE_W-1:0] q_mem [qltu_pkg::DEPTH];
	logic [qltu_pkg::ADDR_W-1:0]  rd_addr;
	logic [qltu_pkg::VALUE_W-1:0] rd_data_q;
	logic                         mem_we;
	logic [qltu_pkg::ADDR_W-1:0]  wr_addr;
	logic [qltu_pkg::VALUE_W-1:0] wr_data;
	logic signed [qltu_pkg::VALUE_W-1:0] nq_sat;
	logic                         do_write;

	always_comb begin
		if (state_q == qltu_pkg::S_READ) begin
			if (cnt_q < qltu_pkg::CNT_W'(qltu_pkg::NUM_ACTIONS)) begin
				rd_addr = tbl_addr(ns_q, qltu_pkg::ADDR_W'(cnt_q));
			end else begin
				rd_addr = tbl_addr(s_q, qltu_pkg::ADDR_W'(a_q));
			end
		end else begin
			rd_addr = tbl_addr(tr_data.following_state, '0);
		end
	end

	assign do_write = train_en_q && in_range_q;
	assign mem_we   = (state_q == qltu_pkg::S_CLEAR) || (wb_go && do_write);
	assign wr_addr  = (state_q == qltu_pkg::S_CLEAR) ? clr_q : tbl_addr(s_q, qltu_pkg::ADDR_W'(a_q));
	assign wr_data  = (state_q == qltu_pkg::S_CLEAR) ? '0 : nq_sat;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			q_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= q_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Row maximum over the serial reads
	// ------------------------------------------------------------------
	logic                                row_rd_s1;
	logic                                first_rd_s1;
	logic signed [qltu_pkg::VALUE_W-1:0] max_q;
	logic signed [qltu_pkg::VALUE_W-1:0] rd_val;

	assign rd_val = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_rd_s1   <= 1'b0;
			first_rd_s1 <= 1'b0;
		end else begin
			row_rd_s1   <= tr_acc || ((state_q == qltu_pkg::S_READ) &&
				(cnt_q < qltu_pkg::CNT_W'(qltu_pkg::NUM_ACTIONS)));
			first_rd_s1 <= tr_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (row_rd_s1) begin
			if (first_rd_s1 || (rd_val > max_q)) begin
				max_q <= rd_val;
			end
		end
	end

	// ------------------------------------------------------------------
	// Arithmetic stages
	// ------------------------------------------------------------------
	logic signed [qltu_pkg::VALUE_W-1:0] best;
	logic signed [qltu_pkg::VALUE_W-1:0] best_q;
	logic signed [qltu_pkg::VALUE_W-1:0] cur_q;
	logic signed [64:0]                  nprod_q;
	logic signed [49:0]                  gprod_q;
	logic signed [qltu_pkg::VALUE_W-1:0] r_norm;
	logic signed [35:0]                  t_q;
	logic signed [53:0]                  aprod_q;
	logic signed [38:0]                  nq;
	logic                                norm_on;

	assign best    = zero_best_q ? '0 : max_q;
	assign norm_on = norm_en_q && (recip_q != '0);
	// Products are floored by dropping the low 16 bits of the signed value
	assign r_norm  = norm_on ? sat32(65'($signed(nprod_q[64:16]))) : r_clip_q;
	assign nq      = 39'(cur_q) + 39'($signed(aprod_q[53:16]));
	assign nq_sat  = sat32(65'(nq));

	always_ff @(posedge clk) begin
		if (state_q == qltu_pkg::S_CUR) begin
			cur_q   <= in_range_q ? rd_val : '0;
			best_q  <= best;
			gprod_q <= 50'($signed({1'b0, gamma_q})) * 50'(best);
			nprod_q <= 65'($signed({1'b0, recip_q})) * 65'(r_clip_q);
		end
		if (state_q == qltu_pkg::S_SUM) begin
			t_q <= 36'(r_norm) + 36'($signed(gprod_q[49:16])) - 36'(cur_q);
		end
		if (state_q == qltu_pkg::S_ALPHA) begin
			aprod_q <= 54'($signed({1'b0, alpha_q})) * 54'(t_q);
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_valid_q <= 1'b0;
		end else if (wb_go) begin
			rs_valid_q <= 1'b1;
		end else if (!rs_stall) begin
			rs_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			rs_q.updated_q   <= do_write ? nq_sat : cur_q;
			rs_q.best_next_q <= best_q;
			rs_q.was_updated <= do_write;
		end
	end

	assign rs_valid = rs_valid_q;
	assign rs_data  = rs_q;

`ifndef SYNTHESIS
	// Table is written only by the clearing pass or at retirement
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == qltu_pkg::S_CLEAR || state_q == qltu_pkg::S_WB))
		else $error("table written outside clear or write-back");

	// A new result appears only after write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rs_valid_q) |-> $past(state_q == qltu_pkg::S_WB))
		else $error("result valid without write-back");

	// A retired update is flagged only when training is enabled and the entry is in range
	assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> (rs_q.was_updated == $past(train_en_q && in_range_q)))
		else $error("was_updated does not match write decision");

	// Requests are never taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qltu_pkg::S_CLEAR) |-> tr_stall)
		else $error("request accepted during table clear");
`endif

endmodule
